### hdl/tmcc_pkg.sv
// Shared types and codes for the timed motor command controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tmcc_pkg;

  // Fixed port widths
  localparam int PIN_W  = 4;
  localparam int GPIO_W = 8;
  localparam int BYTE_W = 8;

  // Defaults for the top-level parameters
  localparam int NUM_MOTORS_DEF    = 4;
  localparam int NUM_GPIO_DEF      = 8;
  localparam int DURATION_BITS_DEF = 16;

  // Byte classes
  localparam logic [BYTE_W-1:0] CLASS_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] MOTOR_CLASS = 8'hC0;
  localparam logic [BYTE_W-1:0] GPIO_CLASS  = 8'hA0;
  localparam logic [BYTE_W-1:0] DONE_CODE   = 8'hD0;

  // Item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Parser phases
  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic [PIN_W-1:0]  drive_left;
    logic [PIN_W-1:0]  drive_right;
    logic [GPIO_W-1:0] gpio_out;
    logic              last;
  } out_t;

  // Everything the result side needs to play out one item's beats
  typedef struct packed {
    logic              is_tick;
    logic [PIN_W-1:0]  done;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic [PIN_W-1:0]  left;
    logic [PIN_W-1:0]  right;
    logic [GPIO_W-1:0] gpio;
  } burst_t;

endpackage

### hdl/tmcc_core.sv
// Command parser, motor timers and pin state; one item per fire.
// Depends on tmcc_pkg.
`timescale 1ns / 1ps

module tmcc_core import tmcc_pkg::*; #(
  parameter int NUM_MOTORS    = NUM_MOTORS_DEF,
  parameter int NUM_GPIO      = NUM_GPIO_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   fire_i,
  input  in_t    item_i,
  output burst_t burst_o
);

  localparam int DW = DURATION_BITS;
  localparam int WW = (DW > 16) ? DW : 16;

  logic [1:0]        phase_q, phase_d;
  logic [BYTE_W-1:0] pend_q, pend_d;
  logic [BYTE_W-1:0] dlow_q, dlow_d;
  logic [DW-1:0]     rem_q [NUM_MOTORS];
  logic [DW-1:0]     rem_d [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] run_q, run_d;
  logic [PIN_W-1:0]  left_q, left_d;
  logic [PIN_W-1:0]  right_q, right_d;
  logic [GPIO_W-1:0] gpio_q, gpio_d;

  logic [WW-1:0]     dur_w;
  logic [DW-1:0]     dur;
  logic [PIN_W-1:0]  done;
  logic              tx_vld;
  logic [BYTE_W-1:0] tx_byte;
  logic [2:0]        gsel;

  // Saturate the 16-bit duration to the counter width
  always_comb begin
    dur_w = WW'({item_i.rx_byte, dlow_q});
    if (dur_w > WW'({DW{1'b1}})) begin
      dur = {DW{1'b1}};
    end else begin
      dur = dur_w[DW-1:0];
    end
  end

  assign gsel = item_i.rx_byte[3:1];

  always_comb begin
    phase_d = phase_q;
    pend_d  = pend_q;
    dlow_d  = dlow_q;
    rem_d   = rem_q;
    run_d   = run_q;
    left_d  = left_q;
    right_d = right_q;
    gpio_d  = gpio_q;
    done    = '0;
    tx_vld  = 1'b0;
    tx_byte = '0;

    if (item_i.kind == KIND_TICK) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        if (run_q[i]) begin
          if (rem_q[i] <= DW'(1)) begin
            rem_d[i] = '0;
            run_d[i] = 1'b0;
            done[i]  = 1'b1;
          end else begin
            rem_d[i] = rem_q[i] - DW'(1);
          end
        end
      end
      left_d  = left_q & ~done;
      right_d = right_q & ~done;
    end else begin
      case (phase_q)
        PH_LOW: begin
          dlow_d  = item_i.rx_byte;
          phase_d = PH_HIGH;
        end
        PH_HIGH: begin
          phase_d = PH_CMD;
          // motor index sits in bits 2:1, direction in bit 0
          for (int i = 0; i < NUM_MOTORS; i++) begin
            if (pend_q[2:1] == 2'(i)) begin
              if (dur == '0) begin
                rem_d[i]   = '0;
                run_d[i]   = 1'b0;
                left_d[i]  = 1'b0;
                right_d[i] = 1'b0;
              end else begin
                rem_d[i]   = dur;
                run_d[i]   = 1'b1;
                left_d[i]  = ~pend_q[0];
                right_d[i] = pend_q[0];
                tx_vld     = 1'b1;
                tx_byte    = pend_q;
              end
            end
          end
        end
        default: begin
          phase_d = PH_CMD;
          if ((item_i.rx_byte & CLASS_MASK) == MOTOR_CLASS) begin
            pend_d  = item_i.rx_byte;
            phase_d = PH_LOW;
          end else if ((item_i.rx_byte & CLASS_MASK) == GPIO_CLASS) begin
            if ({1'b0, gsel} < 4'(NUM_GPIO)) begin
              gpio_d[gsel] = item_i.rx_byte[0];
              tx_vld       = 1'b1;
              tx_byte      = item_i.rx_byte;
            end
          end
        end
      endcase
    end
  end

  // A tick hands over the pins before clearing; the result side clears per beat
  always_comb begin
    burst_o.is_tick  = (item_i.kind == KIND_TICK);
    burst_o.done     = done;
    burst_o.tx_valid = tx_vld;
    burst_o.tx_byte  = tx_byte;
    burst_o.left     = (item_i.kind == KIND_TICK) ? left_q : left_d;
    burst_o.right    = (item_i.kind == KIND_TICK) ? right_q : right_d;
    burst_o.gpio     = gpio_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      pend_q  <= '0;
      dlow_q  <= '0;
      run_q   <= '0;
      left_q  <= '0;
      right_q <= '0;
      gpio_q  <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        rem_q[i] <= '0;
      end
    end else if (fire_i) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      dlow_q  <= dlow_d;
      run_q   <= run_d;
      left_q  <= left_d;
      right_q <= right_d;
      gpio_q  <= gpio_d;
      rem_q   <= rem_d;
    end
  end

  a_pins_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q & right_q) == '0)
    else $error("motor driven both ways");

  a_pins_follow_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q | right_q) == PIN_W'(run_q))
    else $error("drive pins disagree with running motors");

endmodule

### hdl/tmcc_emit.sv
// Result register: plays out one beat per finished motor, or a single beat.
// Depends on tmcc_pkg.
`timescale 1ns / 1ps

module tmcc_emit import tmcc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  burst_t burst_i,
  output logic   ready_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output out_t   out_o
);

  logic              busy_q;
  burst_t            b_q;
  logic [PIN_W-1:0]  low;
  logic [1:0]        idx;
  logic              found;
  logic [PIN_W-1:0]  rest;
  logic              cur_last;
  logic              take;

  // Lowest finished motor of the current tick
  always_comb begin
    low   = '0;
    idx   = '0;
    found = 1'b0;
    for (int i = 0; i < PIN_W; i++) begin
      if (b_q.done[i] && !found) begin
        low[i] = 1'b1;
        idx    = 2'(i);
        found  = 1'b1;
      end
    end
  end

  assign rest     = b_q.done & ~low;
  assign cur_last = !b_q.is_tick || (rest == '0);
  assign take     = busy_q && !out_stall_i;
  assign ready_o  = !busy_q || (take && cur_last);

  always_comb begin
    out_o.last = cur_last;
    out_o.gpio_out = b_q.gpio;
    if (b_q.is_tick) begin
      out_o.tx_valid    = found;
      out_o.tx_byte     = found ? (DONE_CODE | {6'b0, idx}) : '0;
      out_o.drive_left  = b_q.left & ~low;
      out_o.drive_right = b_q.right & ~low;
    end else begin
      out_o.tx_valid    = b_q.tx_valid;
      out_o.tx_byte     = b_q.tx_byte;
      out_o.drive_left  = b_q.left;
      out_o.drive_right = b_q.right;
    end
  end

  assign out_valid_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (load_i) begin
      busy_q <= 1'b1;
    end else if (take && cur_last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      b_q <= burst_i;
    end else if (take && !cur_last) begin
      // advance to the next finished motor
      b_q.done  <= rest;
      b_q.left  <= b_q.left & ~low;
      b_q.right <= b_q.right & ~low;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || (take && cur_last)))
    else $error("burst loaded over pending beats");

  a_hold_mid_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !cur_last) |=> busy_q)
    else $error("tick burst dropped before its last beat");

  a_done_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && b_q.is_tick && found) |-> (out_o.tx_byte[7:4] == DONE_CODE[7:4]))
    else $error("finish notice carries wrong code");

endmodule

### hdl/timed_motor_command_controller_top.sv
// Timed motor command controller: input register, core and result register.
// Depends on tmcc_pkg, tmcc_core, tmcc_emit.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | to block  | in_valid_i / in_stall_o | in_i  (kind, rx_byte)
//   out     | from block| out_valid_o / out_stall_i | out_o (tx, pins, gpio, last)
//
// A serial byte or a tick that finishes no motor yields one beat; a tick that
// finishes k motors holds the result register for k beats, one per cycle while
// out_stall_i is low. An accepted beat passes in_q, then the result register.
// Reset clears the parser, all timers, drive pins and expander levels.
// A stalled result holds; the input register takes the next beat meanwhile.
`timescale 1ns / 1ps

module timed_motor_command_controller_top import tmcc_pkg::*; #(
  parameter int NUM_MOTORS    = NUM_MOTORS_DEF,
  parameter int NUM_GPIO      = NUM_GPIO_DEF,
  parameter int DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic   in_vld_q;
  in_t    in_q;
  logic   fire;
  logic   emit_ready;
  burst_t burst;

  assign fire       = in_vld_q && emit_ready;
  assign in_stall_o = in_vld_q && !emit_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_i;
    end
  end

  tmcc_core #(
    .NUM_MOTORS    (NUM_MOTORS),
    .NUM_GPIO      (NUM_GPIO),
    .DURATION_BITS (DURATION_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_q),
    .burst_o (burst)
  );

  tmcc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .burst_i     (burst),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
